// ----- src/c_lex_pkg.sv -----
// constants, token kind codes and character classes for the c subset lexer
// no dependencies; imported by the lexer core, the result queue and the top level
package c_lex_pkg;

  localparam int KIND_W    = 6;
  localparam int LEN_W     = 16;
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  // keyword candidate ids
  localparam logic [1:0] KW_NONE   = 2'd0;
  localparam logic [1:0] KW_INT    = 2'd1;
  localparam logic [1:0] KW_RETURN = 2'd2;
  localparam logic [1:0] KW_VOID   = 2'd3;

  // token kinds
  localparam logic [KIND_W-1:0] K_IDENT     = 6'd0;
  localparam logic [KIND_W-1:0] K_KW_INT    = 6'd1;
  localparam logic [KIND_W-1:0] K_KW_RETURN = 6'd2;
  localparam logic [KIND_W-1:0] K_KW_VOID   = 6'd3;
  localparam logic [KIND_W-1:0] K_CONST     = 6'd4;
  localparam logic [KIND_W-1:0] K_LPAREN    = 6'd5;
  localparam logic [KIND_W-1:0] K_RPAREN    = 6'd6;
  localparam logic [KIND_W-1:0] K_LBRACE    = 6'd7;
  localparam logic [KIND_W-1:0] K_RBRACE    = 6'd8;
  localparam logic [KIND_W-1:0] K_SEMI      = 6'd9;
  localparam logic [KIND_W-1:0] K_EQEQ      = 6'd10;
  localparam logic [KIND_W-1:0] K_ASSIGN    = 6'd11;
  localparam logic [KIND_W-1:0] K_TILDE     = 6'd12;
  localparam logic [KIND_W-1:0] K_INC       = 6'd13;
  localparam logic [KIND_W-1:0] K_ADDEQ     = 6'd14;
  localparam logic [KIND_W-1:0] K_ADD       = 6'd15;
  localparam logic [KIND_W-1:0] K_MULEQ     = 6'd16;
  localparam logic [KIND_W-1:0] K_MUL       = 6'd17;
  localparam logic [KIND_W-1:0] K_DIVEQ     = 6'd18;
  localparam logic [KIND_W-1:0] K_DIV       = 6'd19;
  localparam logic [KIND_W-1:0] K_MODEQ     = 6'd20;
  localparam logic [KIND_W-1:0] K_MOD       = 6'd21;
  localparam logic [KIND_W-1:0] K_DEC       = 6'd22;
  localparam logic [KIND_W-1:0] K_SUBEQ     = 6'd23;
  localparam logic [KIND_W-1:0] K_SUB       = 6'd24;
  localparam logic [KIND_W-1:0] K_NEQ       = 6'd25;
  localparam logic [KIND_W-1:0] K_NOT       = 6'd26;
  localparam logic [KIND_W-1:0] K_LAND      = 6'd27;
  localparam logic [KIND_W-1:0] K_ANDEQ     = 6'd28;
  localparam logic [KIND_W-1:0] K_AND       = 6'd29;
  localparam logic [KIND_W-1:0] K_LOR       = 6'd30;
  localparam logic [KIND_W-1:0] K_OREQ      = 6'd31;
  localparam logic [KIND_W-1:0] K_OR        = 6'd32;
  localparam logic [KIND_W-1:0] K_XOREQ     = 6'd33;
  localparam logic [KIND_W-1:0] K_XOR       = 6'd34;
  localparam logic [KIND_W-1:0] K_SHLEQ     = 6'd35;
  localparam logic [KIND_W-1:0] K_SHL       = 6'd36;
  localparam logic [KIND_W-1:0] K_LE        = 6'd37;
  localparam logic [KIND_W-1:0] K_LT        = 6'd38;
  localparam logic [KIND_W-1:0] K_SHREQ     = 6'd39;
  localparam logic [KIND_W-1:0] K_SHR       = 6'd40;
  localparam logic [KIND_W-1:0] K_GE        = 6'd41;
  localparam logic [KIND_W-1:0] K_GT        = 6'd42;
  localparam logic [KIND_W-1:0] K_EOF       = 6'd43;
  localparam logic [KIND_W-1:0] K_BADCONST  = 6'd44;
  localparam logic [KIND_W-1:0] K_STRAY     = 6'd45;
  // internal marker for no match, never leaves the core
  localparam logic [KIND_W-1:0] K_NONE      = 6'd63;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b inside {["a":"z"], ["A":"Z"], "_"});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b inside {["0":"9"]});
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b inside {" ", CH_TAB, CH_CR, CH_LF});
  endfunction

  function automatic logic may_extend(input logic [7:0] b);
    return (b inside {"=", "+", "*", "/", "%", "-", "!", "&", "|", "^", "<", ">"});
  endfunction

  function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      ";": k = K_SEMI;
      "=": k = K_ASSIGN;
      "~": k = K_TILDE;
      "+": k = K_ADD;
      "*": k = K_MUL;
      "/": k = K_DIV;
      "%": k = K_MOD;
      "-": k = K_SUB;
      "!": k = K_NOT;
      "&": k = K_AND;
      "|": k = K_OR;
      "^": k = K_XOR;
      "<": k = K_LT;
      ">": k = K_GT;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] c, input logic [7:0] b);
    logic [KIND_W-1:0] k;
    k = K_NONE;
    if (b == "=") begin
      case (c)
        "=": k = K_EQEQ;
        "+": k = K_ADDEQ;
        "*": k = K_MULEQ;
        "/": k = K_DIVEQ;
        "%": k = K_MODEQ;
        "-": k = K_SUBEQ;
        "!": k = K_NEQ;
        "&": k = K_ANDEQ;
        "|": k = K_OREQ;
        "^": k = K_XOREQ;
        "<": k = K_LE;
        ">": k = K_GE;
        default: k = K_NONE;
      endcase
    end else if (b == c) begin
      case (c)
        "+": k = K_INC;
        "-": k = K_DEC;
        "&": k = K_LAND;
        "|": k = K_LOR;
        default: k = K_NONE;
      endcase
    end
    return k;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] id);
    logic [2:0] n;
    case (id)
      KW_INT:    n = 3'd3;
      KW_RETURN: n = 3'd6;
      KW_VOID:   n = 3'd4;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  // character of the keyword at a given position
  function automatic logic [7:0] kw_char(input logic [1:0] id, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (id)
      KW_INT: begin
        case (pos)
          3'd0:    ch = "i";
          3'd1:    ch = "n";
          3'd2:    ch = "t";
          default: ch = 8'h00;
        endcase
      end
      KW_RETURN: begin
        case (pos)
          3'd0:    ch = "r";
          3'd1:    ch = "e";
          3'd2:    ch = "t";
          3'd3:    ch = "u";
          3'd4:    ch = "r";
          3'd5:    ch = "n";
          default: ch = 8'h00;
        endcase
      end
      KW_VOID: begin
        case (pos)
          3'd0:    ch = "v";
          3'd1:    ch = "o";
          3'd2:    ch = "i";
          3'd3:    ch = "d";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [KIND_W-1:0] kw_kind(input logic [1:0] id);
    logic [KIND_W-1:0] k;
    case (id)
      KW_INT:    k = K_KW_INT;
      KW_RETURN: k = K_KW_RETURN;
      KW_VOID:   k = K_KW_VOID;
      default:   k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

// ----- src/c_lex_fifo.sv -----
// result queue: takes up to two tokens per cycle, hands out one per cycle
// depends on c_lex_pkg for depth and pointer widths
module c_lex_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    push_cnt,
  input  logic [WIDTH-1:0]              push0,
  input  logic [WIDTH-1:0]              push1,
  input  logic                          pop,
  output logic [WIDTH-1:0]              head,
  output logic [c_lex_pkg::RES_CNT_W-1:0] count
);
  import c_lex_pkg::*;

  logic [WIDTH-1:0]     mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_PTR_W-1:0] wr_ptr_1;
  logic                 do_pop;

  assign wr_ptr_1 = wr_ptr + RES_PTR_W'(1);
  assign do_pop   = pop && (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push_cnt);
      rd_ptr <= rd_ptr + RES_PTR_W'(do_pop);
      count  <= count + RES_CNT_W'(push_cnt) - RES_CNT_W'(do_pop);
    end
  end

endmodule

// ----- src/c_lex_core.sv -----
// lexer state and per-byte step logic: up to two tokens per accepted item
// depends on c_lex_pkg for kind codes and character classes
module c_lex_core #(
  parameter int OFFSET_BITS = 20,
  parameter int LINE_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       mode,
  input  logic [7:0] source_byte,
  output logic [1:0] res_cnt,
  output logic [c_lex_pkg::KIND_W+OFFSET_BITS+2*LINE_BITS+c_lex_pkg::LEN_W:0] res0,
  output logic [c_lex_pkg::KIND_W+OFFSET_BITS+2*LINE_BITS+c_lex_pkg::LEN_W:0] res1
);
  import c_lex_pkg::*;

  localparam int CW = (OFFSET_BITS + 1 > LINE_BITS) ? OFFSET_BITS + 1 : LINE_BITS;
  localparam logic [LINE_BITS-1:0] LIN_MAX = '1;
  localparam logic [LEN_W-1:0]     LEN_MAX = '1;

  typedef enum logic [2:0] {
    LX_IDLE, LX_IDENT, LX_NUMBER, LX_BADNUM, LX_OP1, LX_OP2
  } lex_mode_t;

  lex_mode_t              lex_mode, lex_mode_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [OFFSET_BITS-1:0] line_start, line_start_next;
  logic [LINE_BITS-1:0]   cur_line, cur_line_next;
  logic [1:0]             kw_id, kw_id_next;
  logic [2:0]             kw_pos, kw_pos_next;
  logic [7:0]             pend_char, pend_char_next;
  logic [OFFSET_BITS-1:0] pend_start, pend_start_next;
  logic [LINE_BITS-1:0]   pend_line, pend_line_next;
  logic [LINE_BITS-1:0]   pend_col, pend_col_next;
  logic [LEN_W-1:0]       pend_len, pend_len_next;

  logic [CW-1:0]          col_diff;
  logic [LINE_BITS-1:0]   here_col;
  logic [LEN_W-1:0]       len_grown;
  logic                   used;
  logic                   f_v, h_v;
  logic [KIND_W-1:0]      f_kind, h_kind, flush_kind;
  logic [LEN_W-1:0]       f_len, h_len, flush_len;
  logic [KIND_W+OFFSET_BITS+2*LINE_BITS+LEN_W-1:0] tok_f, tok_h;

  assign col_diff  = CW'(byte_offset) - CW'(line_start) + CW'(1);
  assign here_col  = (col_diff > CW'(LIN_MAX)) ? LIN_MAX : col_diff[LINE_BITS-1:0];
  assign len_grown = (pend_len == LEN_MAX) ? pend_len : pend_len + LEN_W'(1);

  // kind and length of the pending token if it ends here
  always_comb begin
    flush_kind = K_IDENT;
    flush_len  = pend_len;
    case (lex_mode)
      LX_IDENT: begin
        if (kw_id != KW_NONE && kw_pos == kw_len(kw_id)) begin
          flush_kind = kw_kind(kw_id);
        end
      end
      LX_NUMBER: flush_kind = K_CONST;
      LX_BADNUM: flush_kind = K_BADCONST;
      LX_OP1: begin
        flush_kind = single_kind(pend_char);
        flush_len  = LEN_W'(1);
      end
      LX_OP2: begin
        flush_kind = (pend_char == "<") ? K_SHL : K_SHR;
        flush_len  = LEN_W'(2);
      end
      default: flush_kind = K_IDENT;
    endcase
  end

  always_comb begin
    lex_mode_next    = lex_mode;
    byte_offset_next = byte_offset;
    line_start_next  = line_start;
    cur_line_next    = cur_line;
    kw_id_next       = kw_id;
    kw_pos_next      = kw_pos;
    pend_char_next   = pend_char;
    pend_start_next  = pend_start;
    pend_line_next   = pend_line;
    pend_col_next    = pend_col;
    pend_len_next    = pend_len;
    used   = 1'b0;
    f_v    = 1'b0;
    f_kind = flush_kind;
    f_len  = flush_len;
    h_v    = 1'b0;
    h_kind = K_STRAY;
    h_len  = LEN_W'(1);

    if (mode) begin
      // end of input: flush, then eof, then back to reset state
      f_v              = (lex_mode != LX_IDLE);
      h_v              = 1'b1;
      h_kind           = K_EOF;
      h_len            = '0;
      lex_mode_next    = LX_IDLE;
      byte_offset_next = '0;
      line_start_next  = '0;
      cur_line_next    = LINE_BITS'(1);
      kw_id_next       = KW_NONE;
      kw_pos_next      = '0;
      pend_char_next   = '0;
      pend_start_next  = '0;
      pend_line_next   = '0;
      pend_col_next    = '0;
      pend_len_next    = '0;
    end else begin
      case (lex_mode)
        LX_IDENT: begin
          if (is_alpha(source_byte) || is_digit(source_byte)) begin
            used          = 1'b1;
            pend_len_next = len_grown;
            if (len_grown == LEN_MAX || kw_id == KW_NONE) begin
              kw_id_next  = KW_NONE;
              kw_pos_next = '0;
            end else if (kw_pos < kw_len(kw_id) && kw_char(kw_id, kw_pos) == source_byte) begin
              kw_pos_next = kw_pos + 3'd1;
            end else begin
              kw_id_next  = KW_NONE;
              kw_pos_next = '0;
            end
          end else begin
            f_v = 1'b1;
          end
        end
        LX_NUMBER: begin
          if (is_digit(source_byte)) begin
            used          = 1'b1;
            pend_len_next = len_grown;
          end else if (is_alpha(source_byte)) begin
            used          = 1'b1;
            pend_len_next = len_grown;
            lex_mode_next = LX_BADNUM;
          end else begin
            f_v = 1'b1;
          end
        end
        LX_BADNUM: begin
          if (is_alpha(source_byte)) begin
            used          = 1'b1;
            pend_len_next = len_grown;
          end else begin
            f_v = 1'b1;
          end
        end
        LX_OP1: begin
          if ((pend_char == "<" || pend_char == ">") && source_byte == pend_char) begin
            used          = 1'b1;
            lex_mode_next = LX_OP2;
            pend_len_next = LEN_W'(2);
          end else if (pair_kind(pend_char, source_byte) != K_NONE) begin
            used          = 1'b1;
            f_v           = 1'b1;
            f_kind        = pair_kind(pend_char, source_byte);
            f_len         = LEN_W'(2);
            lex_mode_next = LX_IDLE;
          end else begin
            f_v = 1'b1;
          end
        end
        LX_OP2: begin
          if (source_byte == "=") begin
            used          = 1'b1;
            f_v           = 1'b1;
            f_kind        = (pend_char == "<") ? K_SHLEQ : K_SHREQ;
            f_len         = LEN_W'(3);
            lex_mode_next = LX_IDLE;
          end else begin
            f_v = 1'b1;
          end
        end
        default: lex_mode_next = LX_IDLE;
      endcase

      // a plain flush returns the lexer to idle with no keyword candidate; the byte may then start a new token
      if (f_v && !used) begin
        lex_mode_next = LX_IDLE;
        kw_id_next    = KW_NONE;
        kw_pos_next   = '0;
      end

      if (!used && !is_space(source_byte)) begin
        if (is_digit(source_byte) || is_alpha(source_byte) || may_extend(source_byte)) begin
          pend_start_next = byte_offset;
          pend_line_next  = cur_line;
          pend_col_next   = here_col;
          pend_len_next   = LEN_W'(1);
          if (is_digit(source_byte)) begin
            lex_mode_next = LX_NUMBER;
          end else if (is_alpha(source_byte)) begin
            lex_mode_next = LX_IDENT;
            kw_pos_next   = 3'd1;
            if (source_byte == "i") begin
              kw_id_next = KW_INT;
            end else if (source_byte == "r") begin
              kw_id_next = KW_RETURN;
            end else if (source_byte == "v") begin
              kw_id_next = KW_VOID;
            end else begin
              kw_id_next  = KW_NONE;
              kw_pos_next = '0;
            end
          end else begin
            lex_mode_next  = LX_OP1;
            pend_char_next = source_byte;
          end
        end else begin
          h_v    = 1'b1;
          h_kind = (single_kind(source_byte) != K_NONE) ? single_kind(source_byte) : K_STRAY;
        end
      end

      byte_offset_next = (&byte_offset) ? byte_offset : byte_offset + OFFSET_BITS'(1);
      if (source_byte == CH_LF) begin
        cur_line_next   = (cur_line == LIN_MAX) ? cur_line : cur_line + LINE_BITS'(1);
        line_start_next = byte_offset_next;
      end
    end
  end

  assign tok_f = {f_kind, pend_start, pend_line, pend_col, f_len};
  assign tok_h = {h_kind, byte_offset, cur_line, here_col, h_len};

  always_comb begin
    res_cnt = 2'(f_v) + 2'(h_v);
    if (f_v) begin
      res0 = {tok_f, !h_v};
    end else begin
      res0 = {tok_h, 1'b1};
    end
    res1 = {tok_h, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode    <= LX_IDLE;
      byte_offset <= '0;
      line_start  <= '0;
      cur_line    <= LINE_BITS'(1);
      kw_id       <= KW_NONE;
      kw_pos      <= '0;
    end else if (step) begin
      lex_mode    <= lex_mode_next;
      byte_offset <= byte_offset_next;
      line_start  <= line_start_next;
      cur_line    <= cur_line_next;
      kw_id       <= kw_id_next;
      kw_pos      <= kw_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pend_char  <= pend_char_next;
      pend_start <= pend_start_next;
      pend_line  <= pend_line_next;
      pend_col   <= pend_col_next;
      pend_len   <= pend_len_next;
    end
  end

`ifndef SYNTHESIS
  // a keyword candidate only lives inside an identifier
  assert property (@(posedge clk) disable iff (rst)
    kw_id != KW_NONE |-> lex_mode == LX_IDENT)
    else $error("keyword candidate outside identifier");

  // the current line never starts after the current offset
  assert property (@(posedge clk) disable iff (rst)
    line_start <= byte_offset)
    else $error("line start beyond byte offset");

  // end of input returns the lexer to its reset state
  assert property (@(posedge clk) disable iff (rst)
    step && mode |=> lex_mode == LX_IDLE && byte_offset == '0 && cur_line == LINE_BITS'(1))
    else $error("lexer not cleared after end of input");
`endif

endmodule

// ----- src/c_subset_lexer_unit.sv -----
// Streaming lexer for a small C subset, one source byte per item.
// Input channel (valid/ready): mode 0 carries source_byte, mode 1 marks end
// of input, which flushes any pending token and always yields an EOF token.
// Output channel (valid/ready): one token per item on the output side, with
// kind, start offset, line, column and length; last_of_run marks the final
// token that an input item caused (each item gives zero, one or two tokens).
// A token caused by an item passes the input register, then the lexer step
// writes it into the result queue, from which it is offered.
// Throughput: one item per cycle while items give at most one token and the
// receiver keeps up; an item giving two tokens can hold later items back while
// the single-token output port drains the four-entry result queue.
// Stalls: ready falls while a staged item waits and the queue cannot take two
// more tokens, so nothing is lost; tokens already queued hold until taken.
// Reset: offset 0, line 1, column 1, no pending token, queue empty.
// depends on c_lex_pkg, c_lex_core and c_lex_fifo
module c_subset_lexer_unit #(
  parameter int OFFSET_BITS = 20,
  parameter int LINE_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           mode,
  input  logic [7:0]                     source_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [c_lex_pkg::KIND_W-1:0]   token_kind,
  output logic [OFFSET_BITS-1:0]         start_offset,
  output logic [LINE_BITS-1:0]           line_number,
  output logic [LINE_BITS-1:0]           column_number,
  output logic [c_lex_pkg::LEN_W-1:0]    token_length,
  output logic                           last_of_run
);
  import c_lex_pkg::*;

  localparam int RES_W = KIND_W + OFFSET_BITS + 2 * LINE_BITS + LEN_W + 1;

  logic                 stage_v;
  logic                 stage_mode;
  logic [7:0]           stage_byte;
  logic                 can_go;
  logic                 step;
  logic [1:0]           res_cnt;
  logic [RES_W-1:0]     res0, res1, head;
  logic [RES_CNT_W-1:0] q_count;

  assign can_go   = (q_count <= RES_CNT_W'(RES_DEPTH - 2));
  assign step     = stage_v && can_go;
  assign in_ready = !stage_v || can_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= 1'b0;
    end else if (in_ready) begin
      stage_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_mode <= mode;
      stage_byte <= source_byte;
    end
  end

  c_lex_core #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .mode       (stage_mode),
    .source_byte(stage_byte),
    .res_cnt    (res_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  c_lex_fifo #(
    .WIDTH(RES_W)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push_cnt(step ? res_cnt : 2'd0),
    .push0   (res0),
    .push1   (res1),
    .pop     (out_ready),
    .head    (head),
    .count   (q_count)
  );

  assign out_valid = (q_count != '0);
  assign {token_kind, start_offset, line_number, column_number, token_length, last_of_run} = head;

`ifndef SYNTHESIS
  // the queue never overflows
  assert property (@(posedge clk) disable iff (rst)
    q_count <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  // a step only happens with room for every token it makes
  assert property (@(posedge clk) disable iff (rst)
    step |-> (RES_CNT_W'(q_count) + RES_CNT_W'(res_cnt)) <= RES_CNT_W'(RES_DEPTH))
    else $error("step without queue room");

  // end of input always yields at least the eof token
  assert property (@(posedge clk) disable iff (rst)
    step && stage_mode |-> res_cnt != 2'd0)
    else $error("end of input gave no token");
`endif

endmodule
